// ----- src/bsvgh_pkg.sv -----
// Shared types, constants and helper functions for the bicubic spline block.
// Used by bsvgh_ctrl, bsvgh_dpath and the top level.
// No dependencies.
package bsvgh_pkg;

   localparam int SAMPLE_W = 16;
   localparam int FRAC_W   = 16;
   localparam int INV_W    = 16;
   localparam int INV_FRAC = 8;
   localparam int DATA_W   = 56;
   localparam int STORE_W  = 48;
   localparam int OUT_W    = 32;
   localparam int SPLIT_W  = 28;
   localparam int MUL_W    = SPLIT_W + 1;
   localparam int PROD_W   = MUL_W + INV_W + 1;
   localparam int ACC_W    = 74;
   localparam int NROW     = 4;
   localparam int NRES     = 6;
   localparam int CSR_IDX_W = 1;

   localparam logic [INV_W-1:0] INV_RESET = 16'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_INV_DX_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_DX_Y = 1'b1;

   // datapath operations
   localparam logic [4:0] OP_NOP      = 5'd0;
   localparam logic [4:0] OP_LOAD_ROW = 5'd1;
   localparam logic [4:0] OP_LOAD_COL = 5'd2;
   localparam logic [4:0] OP_DIFF     = 5'd3;
   localparam logic [4:0] OP_R        = 5'd4;
   localparam logic [4:0] OP_S        = 5'd5;
   localparam logic [4:0] OP_R3       = 5'd6;
   localparam logic [4:0] OP_MLO      = 5'd7;
   localparam logic [4:0] OP_MHI      = 5'd8;
   localparam logic [4:0] OP_A        = 5'd9;
   localparam logic [4:0] OP_T        = 5'd10;
   localparam logic [4:0] OP_V        = 5'd11;
   localparam logic [4:0] OP_C        = 5'd12;
   localparam logic [4:0] OP_CS       = 5'd13;
   localparam logic [4:0] OP_D        = 5'd14;
   localparam logic [4:0] OP_ROWST    = 5'd15;
   localparam logic [4:0] OP_KEEP     = 5'd16;
   localparam logic [4:0] OP_SCALE    = 5'd17;
   localparam logic [4:0] OP_OUT      = 5'd18;

   // multiplier operand source
   localparam logic [1:0] SRC_R   = 2'd0;
   localparam logic [1:0] SRC_X   = 2'd1;
   localparam logic [1:0] SRC_RES = 2'd2;

   // multiplier coefficient select
   localparam logic [1:0] MS_FRACX = 2'd0;
   localparam logic [1:0] MS_FRACY = 2'd1;
   localparam logic [1:0] MS_INVX  = 2'd2;
   localparam logic [1:0] MS_INVY  = 2'd3;

   localparam logic [4:0] CUBIC_LAST = 5'd19;
   localparam logic [2:0] SCALE_LAST = 3'd7;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_0;
      logic signed [SAMPLE_W-1:0] sample_1;
      logic signed [SAMPLE_W-1:0] sample_2;
      logic signed [SAMPLE_W-1:0] sample_3;
      logic [FRAC_W-1:0]          frac_x;
      logic [FRAC_W-1:0]          frac_y;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] value;
      logic signed [OUT_W-1:0] grad_x;
      logic signed [OUT_W-1:0] grad_y;
      logic signed [OUT_W-1:0] hess_xx;
      logic signed [OUT_W-1:0] hess_xy;
      logic signed [OUT_W-1:0] hess_yy;
   } rsp_type;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] src;
      logic [2:0] arg;
      logic [1:0] msel;
      logic [1:0] row;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } stat_type;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] src;
   } step_type;

   typedef struct packed {
      logic [2:0] dst;
      logic       inv_y;
   } scale_type;

   // one cubic evaluation: value, slope and curvature
   function automatic step_type cubic_step(input logic [4:0] idx);
      step_type st;
      st.src = SRC_X;
      case (idx)
         5'd0:  st.op = OP_DIFF;
         5'd1:  st.op = OP_R;
         5'd2:  st.op = OP_S;
         5'd3:  begin st.op = OP_MLO; st.src = SRC_R; end
         5'd4:  begin st.op = OP_MHI; st.src = SRC_R; end
         5'd5:  st.op = OP_A;
         5'd6:  st.op = OP_MLO;
         5'd7:  st.op = OP_MHI;
         5'd8:  st.op = OP_T;
         5'd9:  st.op = OP_MLO;
         5'd10: st.op = OP_MHI;
         5'd11: st.op = OP_V;
         5'd12: st.op = OP_R3;
         5'd13: st.op = OP_MLO;
         5'd14: st.op = OP_MHI;
         5'd15: st.op = OP_C;
         5'd16: st.op = OP_CS;
         5'd17: st.op = OP_MLO;
         5'd18: st.op = OP_MHI;
         5'd19: st.op = OP_D;
         default: st.op = OP_NOP;
      endcase
      return st;
   endfunction

   // derivative scaling: x first, then y for mixed terms
   function automatic scale_type scale_entry(input logic [2:0] idx);
      scale_type se;
      case (idx)
         3'd0: se = '{dst: 3'd1, inv_y: 1'b0};
         3'd1: se = '{dst: 3'd2, inv_y: 1'b1};
         3'd2: se = '{dst: 3'd3, inv_y: 1'b0};
         3'd3: se = '{dst: 3'd3, inv_y: 1'b0};
         3'd4: se = '{dst: 3'd4, inv_y: 1'b0};
         3'd5: se = '{dst: 3'd4, inv_y: 1'b1};
         3'd6: se = '{dst: 3'd5, inv_y: 1'b1};
         default: se = '{dst: 3'd5, inv_y: 1'b1};
      endcase
      return se;
   endfunction

   function automatic logic signed [STORE_W-1:0] sat_store(input logic signed [DATA_W-1:0] x);
      logic signed [STORE_W-1:0] y;
      if ((&x[DATA_W-1:STORE_W-1]) || !(|x[DATA_W-1:STORE_W-1]))
         y = x[STORE_W-1:0];
      else if (x[DATA_W-1])
         y = {1'b1, {(STORE_W-1){1'b0}}};
      else
         y = {1'b0, {(STORE_W-1){1'b1}}};
      return y;
   endfunction

   // Q.16 store to Q16.16 output: no shift, saturate only
   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [STORE_W-1:0] x);
      logic signed [OUT_W-1:0] y;
      if ((&x[STORE_W-1:OUT_W-1]) || !(|x[STORE_W-1:OUT_W-1]))
         y = x[OUT_W-1:0];
      else if (x[STORE_W-1])
         y = {1'b1, {(OUT_W-1){1'b0}}};
      else
         y = {1'b0, {(OUT_W-1){1'b1}}};
      return y;
   endfunction

endpackage

// ----- src/bsvgh_dpath.sv -----
// Datapath: row/column cubic registers, shared 29x17 multiplier, row store,
// result registers and the output register.
// Depends on bsvgh_pkg.
module bsvgh_dpath import bsvgh_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  req_type              req_data,
   input  logic [INV_W-1:0]     inv_x,
   input  logic [INV_W-1:0]     inv_y,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data
);

   localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1);

   logic signed [DATA_W-1:0]  p_ff [NROW];
   logic signed [DATA_W-1:0]  p_in [NROW];
   logic signed [DATA_W-1:0]  d20_ff, d20_in, d21_ff, d21_in;
   logic signed [DATA_W-1:0]  r_ff, r_in, s_ff, s_in, x_ff, x_in;
   logic signed [STORE_W-1:0] v_ff, v_in, d_ff, d_in, dd_ff, dd_in;
   logic signed [STORE_W-1:0] rv_ff [NROW];
   logic signed [STORE_W-1:0] rv_in [NROW];
   logic signed [STORE_W-1:0] rs_ff [NROW];
   logic signed [STORE_W-1:0] rs_in [NROW];
   logic signed [STORE_W-1:0] rc_ff [NROW];
   logic signed [STORE_W-1:0] rc_in [NROW];
   logic signed [STORE_W-1:0] res_ff [NRES];
   logic signed [STORE_W-1:0] res_in [NRES];
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      sh8_ff, sh8_in;
   logic [FRAC_W-1:0]         fx_ff, fx_in, fy_ff, fy_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic signed [DATA_W-1:0]  mul_x;
   logic [INV_W-1:0]          mul_m;
   logic signed [MUL_W-1:0]   mul_a;
   logic signed [PROD_W-1:0]  prod;
   logic                      is_inv;
   logic signed [ACC_W-1:0]   rnd;
   logic signed [ACC_W-1:0]   mq_w;
   logic signed [DATA_W-1:0]  mq;

   // shared multiplier: low 28 bits first, signed upper part second
   always_comb begin
      case (cmd.src)
         SRC_R:   mul_x = r_ff;
         SRC_X:   mul_x = x_ff;
         default: mul_x = DATA_W'(res_ff[cmd.arg]);
      endcase
      case (cmd.msel)
         MS_FRACX: mul_m = fx_ff;
         MS_FRACY: mul_m = fy_ff;
         MS_INVX:  mul_m = inv_x;
         default:  mul_m = inv_y;
      endcase
      is_inv = (cmd.msel == MS_INVX) || (cmd.msel == MS_INVY);
      if (cmd.op == OP_MHI)
         mul_a = MUL_W'($signed(mul_x[DATA_W-1:SPLIT_W]));
      else
         mul_a = {1'b0, mul_x[SPLIT_W-1:0]};
      prod = mul_a * $signed({1'b0, mul_m});
      rnd = is_inv ? (ACC_W'(1) << (INV_FRAC - 1)) : (ACC_W'(1) << (FRAC_W - 1));
      mq_w = sh8_ff ? (acc_ff >>> INV_FRAC) : (acc_ff >>> FRAC_W);
      mq = mq_w[DATA_W-1:0];
   end

   always_comb begin
      p_in = p_ff;
      d20_in = d20_ff;
      d21_in = d21_ff;
      r_in = r_ff;
      s_in = s_ff;
      x_in = x_ff;
      v_in = v_ff;
      d_in = d_ff;
      dd_in = dd_ff;
      rv_in = rv_ff;
      rs_in = rs_ff;
      rc_in = rc_ff;
      res_in = res_ff;
      acc_in = acc_ff;
      sh8_in = sh8_ff;
      fx_in = fx_ff;
      fy_in = fy_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (cmd.op)
         OP_LOAD_ROW: begin
            p_in[0] = DATA_W'(req_data.sample_0) <<< FRAC_W;
            p_in[1] = DATA_W'(req_data.sample_1) <<< FRAC_W;
            p_in[2] = DATA_W'(req_data.sample_2) <<< FRAC_W;
            p_in[3] = DATA_W'(req_data.sample_3) <<< FRAC_W;
            if (cmd.row == 2'd0) begin
               fx_in = req_data.frac_x;
               fy_in = req_data.frac_y;
            end
         end
         OP_LOAD_COL: begin
            for (int i = 0; i < NROW; i++) begin
               case (cmd.arg)
                  3'd0:    p_in[i] = DATA_W'(rv_ff[i]);
                  3'd1:    p_in[i] = DATA_W'(rs_ff[i]);
                  default: p_in[i] = DATA_W'(rc_ff[i]);
               endcase
            end
         end
         OP_DIFF: begin
            d20_in = p_ff[2] - p_ff[0];
            d21_in = p_ff[2] - p_ff[1];
            x_in   = p_ff[3] - p_ff[0];
         end
         OP_R:  r_in = x_ff - d21_ff - (d21_ff <<< 1);
         OP_S:  s_in = r_ff - (d21_ff <<< 1) + d20_ff;
         OP_R3: x_in = r_ff + (r_ff <<< 1);
         OP_MLO: begin
            acc_in = ACC_W'(prod) + rnd;
            sh8_in = is_inv;
         end
         OP_MHI: acc_in = acc_ff + (ACC_W'(prod) <<< SPLIT_W);
         OP_A:  x_in = mq - s_ff;
         OP_T:  x_in = mq + d20_ff;
         OP_V:  v_in = sat_store(p_ff[1] + ((mq + ONE) >>> 1));
         OP_C: begin
            x_in  = mq - s_ff;
            dd_in = sat_store(mq - s_ff);
         end
         OP_CS: x_in = x_ff - s_ff;
         OP_D:  d_in = sat_store((mq + d20_ff + ONE) >>> 1);
         OP_ROWST: begin
            rv_in[cmd.row] = v_ff;
            rs_in[cmd.row] = d_ff;
            rc_in[cmd.row] = dd_ff;
         end
         OP_KEEP: begin
            case (cmd.arg)
               3'd0: begin
                  res_in[0] = v_ff;
                  res_in[1] = d_ff;
                  res_in[3] = dd_ff;
               end
               3'd1: begin
                  res_in[2] = v_ff;
                  res_in[4] = d_ff;
               end
               default: res_in[5] = v_ff;
            endcase
         end
         OP_SCALE: res_in[cmd.arg] = sat_store(mq);
         OP_OUT: begin
            rsp_in.value   = sat_out(res_ff[0]);
            rsp_in.grad_x  = sat_out(res_ff[1]);
            rsp_in.grad_y  = sat_out(res_ff[2]);
            rsp_in.hess_xx = sat_out(res_ff[3]);
            rsp_in.hess_xy = sat_out(res_ff[4]);
            rsp_in.hess_yy = sat_out(res_ff[5]);
            rsp_valid_in   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fx_ff <= '0;
         fy_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         fx_ff <= fx_in;
         fy_ff <= fy_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      d20_ff <= d20_in;
      d21_ff <= d21_in;
      r_ff <= r_in;
      s_ff <= s_in;
      x_ff <= x_in;
      v_ff <= v_in;
      d_ff <= d_in;
      dd_ff <= dd_in;
      rv_ff <= rv_in;
      rs_ff <= rs_in;
      rc_ff <= rc_in;
      res_ff <= res_in;
      acc_ff <= acc_in;
      sh8_ff <= sh8_in;
      rsp_ff <= rsp_in;
   end

   assign stat.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ----- src/bsvgh_ctrl.sv -----
// Controller: sequences the row pass, the three column passes, the
// derivative scaling and the output transfer. Depends on bsvgh_pkg.
module bsvgh_ctrl import bsvgh_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CUBIC = 3'd1;
   localparam logic [2:0] ST_ROWST = 3'd2;
   localparam logic [2:0] ST_LOADC = 3'd3;
   localparam logic [2:0] ST_KEEP  = 3'd4;
   localparam logic [2:0] ST_SCALE = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [1:0] row_ff, row_in;
   logic [1:0] col_ff, col_in;
   logic       colph_ff, colph_in;
   logic [2:0] sj_ff, sj_in;
   logic [1:0] sub_ff, sub_in;
   step_type   st;
   scale_type  se;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      row_in = row_ff;
      col_in = col_ff;
      colph_in = colph_ff;
      sj_in = sj_ff;
      sub_in = sub_ff;
      req_ready = 1'b0;
      st = cubic_step(step_ff);
      se = scale_entry(sj_ff);
      cmd.op = OP_NOP;
      cmd.src = SRC_X;
      cmd.arg = {1'b0, col_ff};
      cmd.msel = colph_ff ? MS_FRACX : MS_FRACY;
      cmd.row = row_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_LOAD_ROW;
               step_in = '0;
               colph_in = 1'b0;
               state_in = ST_CUBIC;
            end
         end
         ST_CUBIC: begin
            cmd.op = st.op;
            cmd.src = st.src;
            if (step_ff == CUBIC_LAST)
               state_in = colph_ff ? ST_KEEP : ST_ROWST;
            else
               step_in = step_ff + 5'd1;
         end
         ST_ROWST: begin
            cmd.op = OP_ROWST;
            if (row_ff == 2'(NROW - 1)) begin
               row_in = '0;
               col_in = '0;
               colph_in = 1'b1;
               state_in = ST_LOADC;
            end else begin
               row_in = row_ff + 2'd1;
               state_in = ST_IDLE;
            end
         end
         ST_LOADC: begin
            cmd.op = OP_LOAD_COL;
            step_in = '0;
            state_in = ST_CUBIC;
         end
         ST_KEEP: begin
            cmd.op = OP_KEEP;
            if (col_ff == 2'd2) begin
               sj_in = '0;
               sub_in = '0;
               state_in = ST_SCALE;
            end else begin
               col_in = col_ff + 2'd1;
               state_in = ST_LOADC;
            end
         end
         ST_SCALE: begin
            cmd.src = SRC_RES;
            cmd.arg = se.dst;
            cmd.msel = se.inv_y ? MS_INVY : MS_INVX;
            case (sub_ff)
               2'd0: begin
                  cmd.op = OP_MLO;
                  sub_in = 2'd1;
               end
               2'd1: begin
                  cmd.op = OP_MHI;
                  sub_in = 2'd2;
               end
               default: begin
                  cmd.op = OP_SCALE;
                  sub_in = 2'd0;
                  if (sj_ff == SCALE_LAST)
                     state_in = ST_OUT;
                  else
                     sj_in = sj_ff + 3'd1;
               end
            endcase
         end
         ST_OUT: begin
            // wait until the previous result has been transferred
            if (!stat.rsp_busy) begin
               cmd.op = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
         colph_ff <= 1'b0;
         sj_ff <= '0;
         sub_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         row_ff <= row_in;
         col_ff <= col_in;
         colph_ff <= colph_in;
         sj_ff <= sj_in;
         sub_ff <= sub_in;
      end
   end

endmodule

// ----- src/bicubic_spline_value_gradient_hessian.sv -----
// Top level of the bicubic Catmull-Rom block: inverse spacing registers,
// controller and datapath. Depends on bsvgh_pkg, bsvgh_ctrl, bsvgh_dpath.
//
// Usage:
//  - req_*: one transfer per patch row, four rows make a patch. frac_x and
//    frac_y are taken from the first row only.
//  - rsp_*: one result (value, gradient, Hessian, Q16.16 saturated) per
//    patch, held in an output register until transferred.
//  - csr_*: write-only inverse spacings, index 0 along x, 1 along y,
//    both 256 (1.0) after reset. Write while the block is idle.
// Flow: every row goes through accept, the 20 steps of the cubic
// sequence and the row store; the next row is accepted only after the
// previous row is stored. The fourth row adds three column cubics and
// eight derivative scalings, and no new row is taken until its result
// is written to the output register. The pace is set by the single
// 29x17 multiplier, which forms each product as a low and an upper half.
// Reset (synchronous) empties the patch and the output register.
// A stalled receiver does not stop row processing; only the final output
// write waits until the previous result has been transferred.
module bicubic_spline_value_gradient_hessian import bsvgh_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [INV_W-1:0]     csr_wdata
);

   logic [INV_W-1:0] inv_x_ff, inv_x_in;
   logic [INV_W-1:0] inv_y_ff, inv_y_in;
   cmd_type          cmd;
   stat_type         stat;

   always_comb begin
      inv_x_in = inv_x_ff;
      inv_y_in = inv_y_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_INV_DX_X: inv_x_in = csr_wdata;
            CSR_INV_DX_Y: inv_y_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_x_ff <= INV_RESET;
         inv_y_ff <= INV_RESET;
      end else begin
         inv_x_ff <= inv_x_in;
         inv_y_ff <= inv_y_in;
      end
   end

   bsvgh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bsvgh_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .inv_x     (inv_x_ff),
      .inv_y     (inv_y_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/bsvgh_checker.sv -----
// Checker for the bicubic spline block: follows row and result transfers,
// predicts each patch result and compares it field by field.
// Depends on bsvgh_pkg for the payload types and register indexes.
`timescale 1ns / 1ps
module bsvgh_checker import bsvgh_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [INV_W-1:0]     csr_wdata,
   output int                   fail_count,
   output int                   pending,
   output int                   rows_seen,
   output int                   patches_seen
);

   typedef struct {
      longint v;
      longint d;
      longint dd;
   } cubic_res_t;

   rsp_type    patch_results[$];
   longint     row_val[4];
   longint     row_slp[4];
   longint     row_crv[4];
   logic [1:0] row_idx;
   logic [15:0] frac_x_q, frac_y_q;
   logic [15:0] inv_x, inv_y;
   string      field_name[6] = '{"value", "grad_x", "grad_y", "hess_xx", "hess_xy",
                                 "hess_yy"};

   function automatic longint rnd_shr(input longint v, input int n);
      if (n == 0) return v;
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   // round(x*m / 2^n), ties up; split so the product stays in 64 bits
   function automatic longint mul_frac(input longint x, input longint m, input int n);
      longint hi, lo;
      hi = x >>> n;
      lo = x - (hi <<< n);
      return hi * m + ((lo * m + (64'sd1 <<< (n - 1))) >>> n);
   endfunction

   function automatic longint clip(input longint x, input int bits);
      longint lim;
      lim = 64'sd1 <<< (bits - 1);
      if (x >= lim) return lim - 1;
      if (x < -lim) return -lim;
      return x;
   endfunction

   function automatic cubic_res_t catmull_rom(input longint p[4], input longint f);
      cubic_res_t o;
      longint d20, d30, d21, r, s, t, c;
      d20 = p[2] - p[0];
      d30 = p[3] - p[0];
      d21 = p[2] - p[1];
      r = d30 - 3 * d21;
      s = r - 2 * d21 + d20;
      t = mul_frac(mul_frac(r, f, FRAC_W) - s, f, FRAC_W) + d20;
      c = mul_frac(3 * r, f, FRAC_W) - s;
      o.v = clip(p[1] + rnd_shr(mul_frac(t, f, FRAC_W), 1), STORE_W);
      o.dd = clip(c, STORE_W);
      o.d = clip(rnd_shr(mul_frac(c - s, f, FRAC_W) + d20, 1), STORE_W);
      return o;
   endfunction

   function automatic longint spacing(input longint x, input logic [15:0] inv);
      return clip(mul_frac(x, longint'(inv), INV_FRAC), STORE_W);
   endfunction

   function automatic logic [OUT_W-1:0] to_q16(input longint x);
      longint q;
      q = clip(rnd_shr(x, FRAC_W - 16), OUT_W);
      return q[OUT_W-1:0];
   endfunction

   task automatic take_row(input req_type rq);
      longint p[4];
      cubic_res_t rc, cv, cs, cc;
      rsp_type e;
      if (row_idx == 2'd0) begin
         frac_x_q = rq.frac_x;
         frac_y_q = rq.frac_y;
      end
      p[0] = longint'(rq.sample_0) * 65536;
      p[1] = longint'(rq.sample_1) * 65536;
      p[2] = longint'(rq.sample_2) * 65536;
      p[3] = longint'(rq.sample_3) * 65536;
      rc = catmull_rom(p, longint'(frac_y_q));
      row_val[row_idx] = rc.v;
      row_slp[row_idx] = rc.d;
      row_crv[row_idx] = rc.dd;
      if (row_idx == 2'd3) begin
         cv = catmull_rom(row_val, longint'(frac_x_q));
         cs = catmull_rom(row_slp, longint'(frac_x_q));
         cc = catmull_rom(row_crv, longint'(frac_x_q));
         e.value   = to_q16(cv.v);
         e.grad_x  = to_q16(spacing(cv.d, inv_x));
         e.grad_y  = to_q16(spacing(cs.v, inv_y));
         e.hess_xx = to_q16(spacing(spacing(cv.dd, inv_x), inv_x));
         e.hess_xy = to_q16(spacing(spacing(cs.d, inv_x), inv_y));
         e.hess_yy = to_q16(spacing(spacing(cc.v, inv_y), inv_y));
         patch_results.push_back(e);
      end
      row_idx = row_idx + 2'd1;
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type e;
      logic [OUT_W-1:0] ev, gv;
      bit bad;
      if (patch_results.size() == 0) begin
         fail_count++;
         if (fail_count <= 10) $display("unexpected result transfer: %h", got);
         return;
      end
      e = patch_results.pop_front();
      bad = 0;
      for (int i = 0; i < NRES; i++) begin
         ev = e[(NRES-1-i)*OUT_W +: OUT_W];
         gv = got[(NRES-1-i)*OUT_W +: OUT_W];
         if (ev !== gv) begin
            if (!bad) fail_count++;
            bad = 1;
            if (fail_count <= 10)
               $display("patch %0d %s: expected %0d, got %0d", patches_seen,
                        field_name[i], $signed(ev), $signed(gv));
         end
      end
      patches_seen++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      rows_seen = 0;
      patches_seen = 0;
      row_idx = 2'd0;
      frac_x_q = '0;
      frac_y_q = '0;
      inv_x = INV_RESET;
      inv_y = INV_RESET;
   end

   always @(posedge clock) begin
      if (reset) begin
         row_idx = 2'd0;
         frac_x_q = '0;
         frac_y_q = '0;
         inv_x = INV_RESET;
         inv_y = INV_RESET;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_INV_DX_X) inv_x = csr_wdata;
            else if (csr_index == CSR_INV_DX_Y) inv_y = csr_wdata;
         end
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (req_valid && req_ready) begin
            take_row(req_data);
            rows_seen++;
         end
      end
      pending = patch_results.size();
   end

endmodule

// ----- tb/testbench.sv -----
// Top of the bicubic spline testbench: clock, reset, row stimulus, register
// writes and receiver stalls. Depends on bsvgh_pkg, bsvgh_checker and the block.
`timescale 1ns / 1ps
module testbench;
   import bsvgh_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_INV_DX_X;
   logic [INV_W-1:0]     csr_wdata = '0;

   int fail_count, pending, rows_seen, patches_seen;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;

   always #1 clock = ~clock;

   bicubic_spline_value_gradient_hessian u_dut (.*);

   bsvgh_checker u_checker (.*);

   // receiver: random stalls, plus one long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_row(input req_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [INV_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] pick_sample(input int mode);
      case (mode)
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'(int'($urandom_range(15, 0)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   // one patch: four rows, the fractions only matter on the first
   task automatic send_patch(input int mode, input logic [15:0] fx, input logic [15:0] fy);
      req_type rq;
      for (int r = 0; r < NROW; r++) begin
         rq.sample_0 = pick_sample(mode);
         rq.sample_1 = pick_sample(mode);
         rq.sample_2 = pick_sample(mode);
         rq.sample_3 = pick_sample(mode);
         rq.frac_x = (r == 0) ? fx : 16'($urandom);
         rq.frac_y = (r == 0) ? fy : 16'($urandom);
         send_row(rq);
      end
   endtask

   task automatic random_patch;
      int m;
      logic [15:0] fx, fy;
      m = $urandom_range(9);
      fx = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
      fy = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
      send_patch((m < 1) ? 0 : (m < 2) ? 1 : (m < 3) ? 2 : 3, fx, fy);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes of samples and fractions, default spacings
      send_patch(0, 16'h0000, 16'h0000);
      send_patch(1, 16'hFFFF, 16'hFFFF);
      send_patch(3, 16'h8000, 16'h8000);
      send_patch(3, 16'h0000, 16'hFFFF);
      send_patch(2, 16'hFFFF, 16'h0001);
      send_patch(3, 16'h5555, 16'hAAAA);

      // no idling; long hold-off so rows back up behind a full output
      hold_cycles = 3000;
      for (int i = 0; i < 75; i++) random_patch();
      drain();

      write_reg(CSR_INV_DX_X, 16'hFFFF);
      write_reg(CSR_INV_DX_Y, 16'hFFFF);
      send_idle_pct = 81;
      recv_stall_pct = 0;
      for (int i = 0; i < 75; i++) random_patch();
      drain();

      write_reg(CSR_INV_DX_X, 16'h0000);
      write_reg(CSR_INV_DX_Y, 16'h0001);
      send_idle_pct = 0;
      recv_stall_pct = 81;
      for (int i = 0; i < 75; i++) random_patch();
      drain();

      write_reg(CSR_INV_DX_X, 16'($urandom));
      write_reg(CSR_INV_DX_Y, 16'($urandom_range(2048, 1)));
      send_idle_pct = 27;
      recv_stall_pct = 27;
      for (int i = 0; i < 75; i++) random_patch();
      drain();

      $display("Covered %0d rows and %0d patch results over four spacing settings",
               rows_seen, patches_seen);
      $display("with sender gaps, receiver stalls and one long output hold-off.");
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
src/bsvgh_pkg.sv
src/bsvgh_dpath.sv
src/bsvgh_ctrl.sv
src/bicubic_spline_value_gradient_hessian.sv
tb/bsvgh_checker.sv
tb/testbench.sv
